// ===== src/ile_pkg.sv =====
package ile_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WORD_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 5;

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   data;
    } cell_cmd_t;

endpackage

// ===== src/ile_cell.sv =====
module ile_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 5
) (
    input  logic                         clk,
    input  ile_pkg::cell_cmd_t           cmd,
    input  logic [CMP_W-1:0]             sel_pos,
    input  logic [ile_pkg::WORD_W-1:0]   left_q,
    input  logic [ile_pkg::WORD_W-1:0]   right_q,
    output logic [ile_pkg::WORD_W-1:0]   q
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [ile_pkg::WORD_W-1:0] word_reg;
    logic [ile_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            ile_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            ile_pkg::CELL_WRITE:
            begin
                if (MY_IDX == sel_pos)
                begin
                    word_next = cmd.data;
                end
            end
            ile_pkg::CELL_INSERT:
            begin
                if (MY_IDX == sel_pos)
                begin
                    word_next = cmd.data;
                end
                else if (MY_IDX > sel_pos)
                begin
                    word_next = left_q;
                end
            end
            ile_pkg::CELL_REMOVE:
            begin
                if (MY_IDX >= sel_pos)
                begin
                    word_next = right_q;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

// ===== src/ile_ctrl.sv =====
module ile_ctrl #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int CMP_W    = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ile_pkg::FUNC_W-1:0]     func,
    input  logic [ile_pkg::POS_W-1:0]      position,
    input  logic [ile_pkg::WORD_W-1:0]     value,
    input  logic [ile_pkg::WORD_W-1:0]     cell_q [CAPACITY],
    output ile_pkg::cell_cmd_t             cmd,
    output logic [CMP_W-1:0]               sel_pos,
    output logic                           done,
    output logic [ile_pkg::WORD_W-1:0]     read_value,
    output logic [ile_pkg::STATUS_W-1:0]   status,
    output logic [ile_pkg::LEN_W-1:0]      list_length
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          done_reg;
    logic [ile_pkg::WORD_W-1:0]    rd_reg;
    logic [ile_pkg::WORD_W-1:0]    rd_next;
    logic [ile_pkg::STATUS_W-1:0]  st_reg;
    logic [ile_pkg::STATUS_W-1:0]  st_next;

    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              fill_ext;
    logic [IDX_W-1:0]              rd_idx;
    logic                          in_range;
    logic                          is_full;

    assign pos_ext  = CMP_W'(position);
    assign fill_ext = CMP_W'(fill_reg);
    assign rd_idx   = IDX_W'(position);
    assign in_range = pos_ext < fill_ext;
    assign is_full  = fill_ext >= CAP_C;

    always_comb
    begin
        fill_next = fill_reg;
        rd_next   = '0;
        st_next   = ile_pkg::ST_OK;
        cmd.op    = ile_pkg::CELL_HOLD;
        cmd.data  = value;
        sel_pos   = pos_ext;
        if (start)
        begin
            unique case (func)
                ile_pkg::FN_APPEND:
                begin
                    sel_pos = fill_ext;
                    if (is_full)
                    begin
                        st_next = ile_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.op    = ile_pkg::CELL_WRITE;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                ile_pkg::FN_READ:
                begin
                    if (!in_range)
                    begin
                        st_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        rd_next = cell_q[rd_idx];
                    end
                end
                ile_pkg::FN_WRITE:
                begin
                    if (!in_range)
                    begin
                        st_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd.op = ile_pkg::CELL_WRITE;
                    end
                end
                ile_pkg::FN_INSERT:
                begin
                    if (pos_ext > fill_ext)
                    begin
                        st_next = ile_pkg::ST_RANGE;
                    end
                    else if (is_full)
                    begin
                        st_next = ile_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.op    = ile_pkg::CELL_INSERT;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                ile_pkg::FN_REMOVE:
                begin
                    if (!in_range)
                    begin
                        st_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd.op    = ile_pkg::CELL_REMOVE;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                ile_pkg::FN_CLEAR:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        st_reg <= st_next;
    end

    assign done        = done_reg;
    assign read_value  = rd_reg;
    assign status      = st_reg;
    assign list_length = ile_pkg::LEN_W'(fill_reg);

endmodule

// ===== src/indexed_list_engine_top.sv =====
// Indexed list engine: an ordered list of signed 32-bit words held in a row
// of CAPACITY cells.
// Command channel: drive func, position and value with start high; the
// transaction is taken at the rising edge where start is high and busy low.
// busy stays low, so a new transaction may be issued on every cycle.
// Result channel: done pulses for one cycle, in the cycle after the accepting
// edge, with read_value, status and list_length; the receiver cannot stall
// it and must take it on that cycle.
// Throughput 1 transaction per cycle: every cell loads, takes its left or right
// neighbour, or holds in the same cycle, so insert and remove shift the whole
// tail at once.
// Reads select the word from the CAPACITY cells through one mux.
// Reset empties the list and clears done; stored words are left as they are
// and only become visible once written.
module indexed_list_engine_top #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ile_pkg::FUNC_W-1:0]     func,
    input  logic [ile_pkg::POS_W-1:0]      position,
    input  logic signed [ile_pkg::WORD_W-1:0] value,
    output logic                           done,
    output logic signed [ile_pkg::WORD_W-1:0] read_value,
    output logic [ile_pkg::STATUS_W-1:0]   status,
    output logic [ile_pkg::LEN_W-1:0]      list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;

    ile_pkg::cell_cmd_t            cmd;
    logic [CMP_W-1:0]              sel_pos;
    logic [ile_pkg::WORD_W-1:0]    cell_q [CAPACITY];
    logic                          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ile_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .CMP_W    (CMP_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .func        (func),
        .position    (position),
        .value       (value),
        .cell_q      (cell_q),
        .cmd         (cmd),
        .sel_pos     (sel_pos),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ile_pkg::WORD_W-1:0] left_q;
        logic [ile_pkg::WORD_W-1:0] right_q;

        if (i == 0)
        begin : g_first
            assign left_q = cmd.data;
        end
        else
        begin : g_left
            assign left_q = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_q = cell_q[i];
        end
        else
        begin : g_right
            assign right_q = cell_q[i+1];
        end

        ile_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .sel_pos (sel_pos),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[i])
        );
    end

endmodule

// ===== src/ile_checker.sv =====
module ile_checker #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [ile_pkg::FUNC_W-1:0]     func,
    input  logic                           done,
    input  logic [ile_pkg::WORD_W-1:0]     read_value,
    input  logic [ile_pkg::STATUS_W-1:0]   status,
    input  logic [ile_pkg::LEN_W-1:0]      list_length
);

    localparam logic [ile_pkg::LEN_W-1:0] CAP_LEN = ile_pkg::LEN_W'(CAPACITY);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("transaction accepted without a result on the next cycle");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without an accepted transaction");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ile_pkg::ST_FULL) |-> list_length == CAP_LEN)
        else $error("full status with list not at capacity");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == ile_pkg::FN_CLEAR) |=>
            (list_length == '0 && status == ile_pkg::ST_OK && read_value == '0))
        else $error("clear did not empty the list");

endmodule

bind indexed_list_engine_top ile_checker #(
    .CAPACITY (CAPACITY)
) u_ile_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .list_length (list_length)
);

// ===== bench/tb_indexed_list_engine_top.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_engine_top;

    import ile_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    typedef struct {
        logic [WORD_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    list_length;
    } list_reply_t;

    class list_scoreboard;
        logic [WORD_W-1:0] slots [CAPACITY];
        int unsigned       fill;
        list_reply_t       replies [$];
        int                errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                   logic [WORD_W-1:0] v);
            list_reply_t r;
            r.read_value = '0;
            r.status     = ST_OK;
            case (f)
                FN_APPEND:
                    if (fill >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        slots[fill] = v;
                        fill++;
                    end
                FN_READ:
                    if (p >= fill)
                        r.status = ST_RANGE;
                    else
                        r.read_value = slots[p];
                FN_WRITE:
                    if (p >= fill)
                        r.status = ST_RANGE;
                    else
                        slots[p] = v;
                FN_INSERT:
                    if (p > fill)
                        r.status = ST_RANGE;
                    else if (fill >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = fill; i > p; i--)
                            slots[i] = slots[i-1];
                        slots[p] = v;
                        fill++;
                    end
                FN_REMOVE:
                    if (p >= fill)
                        r.status = ST_RANGE;
                    else
                    begin
                        for (int i = p; i + 1 < fill; i++)
                            slots[i] = slots[i+1];
                        fill--;
                    end
                FN_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            r.list_length = fill[LEN_W-1:0];
            replies.push_back(r);
        endfunction

        task check_reply(logic [WORD_W-1:0] rv, logic [STATUS_W-1:0] st,
                         logic [LEN_W-1:0] len);
            list_reply_t want;
            if (replies.size() == 0)
            begin
                report("result with no transaction waiting", {30'd0, st}, '0);
                return;
            end
            want = replies.pop_front();
            if (rv !== want.read_value)
                report("read_value", rv, want.read_value);
            if (st !== want.status)
                report("status", {30'd0, st}, {30'd0, want.status});
            if (len !== want.list_length)
                report("list_length", {27'd0, len}, {27'd0, want.list_length});
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [FUNC_W-1:0]          func = '0;
    logic [POS_W-1:0]           position = '0;
    logic signed [WORD_W-1:0]   value = '0;
    logic                       busy;
    logic                       done;
    logic signed [WORD_W-1:0]   read_value;
    logic [STATUS_W-1:0]        status;
    logic [LEN_W-1:0]           list_length;

    int unsigned    cycles = 0;
    list_scoreboard sb = new();

    indexed_list_engine_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** indexed_list_engine_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_reply(read_value, status, list_length);
    end

    // called at a rising edge; returns at the edge that takes the transaction
    task send_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, logic [WORD_W-1:0] v);
        func     <= f;
        position <= p;
        value    <= v;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(f, p, v);
    endtask

    task idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task wait_drained;
        start <= 1'b0;
        @(posedge clk);
        while (sb.replies.size() != 0)
            @(posedge clk);
    endtask

    function logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] f);
        int unsigned top;
        int unsigned r;
        int unsigned near;
        top = (f == FN_INSERT) ? sb.fill : ((sb.fill > 0) ? sb.fill - 1 : 0);
        r   = $urandom_range(0, 9);
        if (r < 7)
            return POS_W'($urandom_range(0, top));
        else if (r < 9)
        begin
            near = top + $urandom_range(0, 2);
            return (near > 31) ? 5'd31 : POS_W'(near);
        end
        else
            return POS_W'($urandom_range(0, 31));
    endfunction

    function logic [FUNC_W-1:0] pick_func(int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return FN_CLEAR;
        if (r < 4)
            return ($urandom_range(0, 1) == 0) ? FN_SPARE_6 : FN_SPARE_7;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                if (r < 40)      return FN_APPEND;
                else if (r < 70) return FN_INSERT;
                else if (r < 80) return FN_READ;
                else if (r < 90) return FN_WRITE;
                else             return FN_REMOVE;
            MODE_SHRINK:
                if (r < 50)      return FN_REMOVE;
                else if (r < 65) return FN_READ;
                else if (r < 80) return FN_WRITE;
                else if (r < 90) return FN_APPEND;
                else             return FN_INSERT;
            default:
                return FUNC_W'($urandom_range(FN_APPEND, FN_REMOVE));
        endcase
    endfunction

    initial
    begin
        int             mode;
        int             run_left;
        bit             idling;
        logic [FUNC_W-1:0] f;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, boundaries, every operation, spare codes
        send_request(FN_READ,    5'd0,  32'h1234_5678);
        send_request(FN_REMOVE,  5'd0,  32'h0);
        send_request(FN_INSERT,  5'd1,  32'h1);
        send_request(FN_INSERT,  5'd0,  32'h8000_0000);
        send_request(FN_APPEND,  5'd31, 32'h7fff_ffff);
        send_request(FN_APPEND,  5'd0,  32'hffff_ffff);
        send_request(FN_INSERT,  5'd3,  32'h5a5a_5a5a);
        send_request(FN_INSERT,  5'd5,  32'h2);
        send_request(FN_INSERT,  5'd16, 32'h3);
        send_request(FN_INSERT,  5'd1,  32'h0000_0000);
        send_request(FN_READ,    5'd0,  32'h0);
        send_request(FN_READ,    5'd4,  32'h0);
        send_request(FN_READ,    5'd5,  32'h0);
        send_request(FN_WRITE,   5'd1,  32'ha5a5_a5a5);
        send_request(FN_WRITE,   5'd31, 32'hffff_ffff);
        send_request(FN_READ,    5'd1,  32'h0);
        send_request(FN_REMOVE,  5'd0,  32'h0);
        send_request(FN_REMOVE,  5'd16, 32'h0);
        send_request(FN_READ,    5'd0,  32'h0);
        send_request(FN_SPARE_6, 5'd31, 32'hffff_ffff);
        send_request(FN_SPARE_7, 5'd0,  32'h0);
        send_request(FN_CLEAR,   5'd31, 32'hffff_ffff);
        send_request(FN_READ,    5'd0,  32'h0);
        send_request(FN_APPEND,  5'd0,  32'h0000_0001);

        mode     = MODE_GROW;
        run_left = $urandom_range(20, 60);
        idling   = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (run_left == 0)
            begin
                mode     = $urandom_range(MODE_GROW, MODE_MIXED);
                run_left = $urandom_range(20, 60);
                idling   = 1'($urandom_range(0, 1));
            end
            run_left--;
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (idling && n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 17));
            f = pick_func(mode);
            send_request(f, pick_position(f), pick_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** indexed_list_engine_top: PASSED **");
        else
            $display("** indexed_list_engine_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ile_pkg.sv
src/ile_cell.sv
src/ile_ctrl.sv
src/indexed_list_engine_top.sv
src/ile_checker.sv
bench/tb_indexed_list_engine_top.sv
